FILE: hw/rtl/lnd_pkg.sv
// Shared types and constants of the lane notch detector.
package lnd_pkg;

  typedef enum logic [1:0] {
    KIND_ROW   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_INHIB = 2'd2,
    KIND_RESET = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    VERD_NONE   = 2'd0,
    VERD_LEFT   = 2'd1,
    VERD_CENTER = 2'd2,
    VERD_RIGHT  = 2'd3
  } verdict_e;

  localparam logic [2:0] MSK_NONE   = 3'd0;
  localparam logic [2:0] MSK_LEFT   = 3'd1;
  localparam logic [2:0] MSK_CENTER = 3'd2;
  localparam logic [2:0] MSK_RIGHT  = 3'd4;

  localparam logic [2:0] REG_DEPTH = 3'd0;
  localparam logic [2:0] REG_TOL   = 3'd1;
  localparam logic [2:0] REG_WIDTH = 3'd2;
  localparam logic [2:0] REG_CCOL  = 3'd3;
  localparam logic [2:0] REG_COOL  = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] left_edge;
    logic [7:0] right_edge;
    logic [7:0] lost_left_row;
    logic [7:0] lost_right_row;
    logic       last_row;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  verdict;
    logic        request_published;
    logic [7:0]  target_x;
    logic [7:0]  target_y;
    logic [8:0]  aim_offset;
    logic [7:0]  peak_col;
    logic [7:0]  valley_col;
    logic        laser_left_on;
    logic        laser_center_on;
    logic        laser_right_on;
    logic        buzzer_on;
  } out_item_t;

  // Work handed from front to back.
  typedef enum logic [1:0] {
    OP_VERDICT = 2'd0,
    OP_TICK    = 2'd1,
    OP_INHIB   = 2'd2,
    OP_DETRST  = 2'd3
  } op_e;

  // Classified frame: target and the verdict (NONE for invalid).
  typedef struct packed {
    logic [1:0] op;
    logic       frame_bad;
    logic [1:0] verdict;
    logic [7:0] target_x;
    logic [7:0] target_y;
    logic [7:0] peak_col;
    logic [7:0] valley_col;
  } job_t;

  typedef struct packed {
    logic [7:0] depth;
    logic [7:0] tol;
    logic [7:0] width;
    logic [7:0] ccol;
    logic [7:0] cool;
  } cfg_t;

endpackage

FILE: hw/rtl/lnd_if.sv
// Valid/ready channel interfaces.
interface lnd_in_if;
  import lnd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lnd_out_if;
  import lnd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lnd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: hw/rtl/lnd_front.sv
// Front: row accumulation and frame classification.
module lnd_front import lnd_pkg::*; #(
  parameter int IMAGE_WIDTH    = 188,
  parameter int FIRST_ROW      = 61,
  parameter int ROW_STEP       = 2,
  parameter int ROWS_PER_FRAME = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_ready_o,
  output logic     job_valid_o,
  output job_t     job_o,
  input  logic     job_ready_i
);
  localparam logic [7:0] VALLEY_RST = 8'(IMAGE_WIDTH - 1);
  localparam logic [3:0] LAST_IDX   = 4'(ROWS_PER_FRAME - 1);

  logic [3:0]  row_count_q;
  logic        frame_invalid_q;
  logic [7:0]  top_left_q, top_right_q, peak_left_q, valley_right_q;
  logic [7:0]  peak_row_q, valley_row_q;
  logic        acc;
  logic [11:0] rn;
  logic [7:0]  rn8;
  logic        ok, bad;
  logic [7:0]  lbase, rbase, gap;
  logic [8:0]  ldep, rdep, sx, sy;
  logic        lhit, rhit;
  job_t        job;
  kind_e       kind;

  assign in_ready_o = job_ready_i;
  assign kind = kind_e'(in_data_i.kind);
  assign acc  = in_valid_i && in_ready_o;

  always_comb begin
    rn  = 12'(FIRST_ROW) + 12'(row_count_q) * 12'(ROW_STEP);
    rn8 = rn[7:0];
    ok  = !(rn <= 12'(in_data_i.lost_left_row) || rn <= 12'(in_data_i.lost_right_row));
    if (in_data_i.left_edge <= 8'd1 ||
        (10'(in_data_i.right_edge) + 10'd2) >= 10'(IMAGE_WIDTH)) ok = 1'b0;
    if (in_data_i.left_edge >= in_data_i.right_edge) ok = 1'b0;
    else if ((in_data_i.right_edge - in_data_i.left_edge) < cfg_i.width) ok = 1'b0;
    bad   = frame_invalid_q || !ok || (row_count_q != LAST_IDX);
    lbase = (top_left_q > in_data_i.left_edge) ? top_left_q : in_data_i.left_edge;
    rbase = (top_right_q < in_data_i.right_edge) ? top_right_q : in_data_i.right_edge;
    ldep  = {1'b0, peak_left_q} - {1'b0, lbase};
    rdep  = {1'b0, rbase} - {1'b0, valley_right_q};
    lhit  = !ldep[8] && (ldep[7:0] >= cfg_i.depth);
    rhit  = !rdep[8] && (rdep[7:0] >= cfg_i.depth);
    gap   = (peak_row_q > valley_row_q) ? peak_row_q - valley_row_q
                                        : valley_row_q - peak_row_q;
    sx    = {1'b0, peak_left_q} + {1'b0, valley_right_q};
    sy    = {1'b0, peak_row_q} + {1'b0, valley_row_q};
    job   = '0;
    job.frame_bad = bad;
    case (kind)
      KIND_TICK:  job.op = OP_TICK;
      KIND_INHIB: job.op = OP_INHIB;
      KIND_RESET: job.op = OP_DETRST;
      default:    job.op = OP_VERDICT;
    endcase
    if (!bad) begin
      if (lhit && rhit) begin
        if (gap <= cfg_i.tol) begin
          job.verdict = VERD_CENTER;
          job.target_x = sx[8:1];
          job.target_y = sy[8:1];
        end
      end else if (lhit) begin
        job.verdict = VERD_LEFT;
        job.target_x = peak_left_q;
        job.target_y = peak_row_q;
      end else if (rhit) begin
        job.verdict = VERD_RIGHT;
        job.target_x = valley_right_q;
        job.target_y = valley_row_q;
      end
    end
    if (job.verdict != VERD_NONE) begin
      job.peak_col = peak_left_q;
      job.valley_col = valley_right_q;
    end
  end

  assign job_o       = job;
  assign job_valid_o = in_valid_i && !(kind == KIND_ROW && !in_data_i.last_row);

  always_ff @(posedge clk_i) begin
    if (acc && kind == KIND_ROW && !in_data_i.last_row && row_count_q == 4'd0) begin
      top_left_q  <= in_data_i.left_edge;
      top_right_q <= in_data_i.right_edge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      frame_invalid_q <= 1'b0;
      peak_left_q <= '0;
      valley_right_q <= VALLEY_RST;
      peak_row_q <= '0;
      valley_row_q <= '0;
    end else if (acc) begin
      if (kind == KIND_RESET || (kind == KIND_ROW && in_data_i.last_row)) begin
        row_count_q <= '0;
        frame_invalid_q <= 1'b0;
        peak_left_q <= '0;
        valley_right_q <= VALLEY_RST;
        peak_row_q <= '0;
        valley_row_q <= '0;
      end else if (kind == KIND_ROW) begin
        if (!ok) frame_invalid_q <= 1'b1;
        if (row_count_q != 4'd0) begin
          if (row_count_q >= LAST_IDX) frame_invalid_q <= 1'b1;
          if (in_data_i.left_edge > peak_left_q) begin
            peak_left_q <= in_data_i.left_edge;
            peak_row_q  <= rn8;
          end
          if (in_data_i.right_edge < valley_right_q) begin
            valley_right_q <= in_data_i.right_edge;
            valley_row_q   <= rn8;
          end
        end
        if (row_count_q != 4'd15) row_count_q <= row_count_q + 4'd1;
      end
    end
  end
endmodule

FILE: hw/rtl/lnd_queue.sv
// Two-entry job queue between front and back.
module lnd_queue import lnd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  job_t wr_data_i,
  output logic wr_ready_o,
  output logic rd_valid_o,
  output job_t rd_data_o,
  input  logic rd_ready_i
);
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !wr_ready_o) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_o && !rd_ready_i) |=> rd_valid_o) else $error("entry lost");
`endif
endmodule

FILE: hw/rtl/lnd_back.sv
// Back: re-arm logic, shot timer and result register.
module lnd_back import lnd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_ready_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_ready_i
);
  logic [1:0] rearm_q;
  logic [2:0] pend_q, smask_q, drive_q, drv_d, req;
  logic       armed_q;
  logic [7:0] cool_q;
  logic       ov_q;
  out_item_t  od_q, res;
  logic       take, emits;
  op_e        op;

  assign op = op_e'(job_i.op);
  assign emits = op != OP_DETRST;
  assign job_ready_o = !ov_q || out_ready_i || !emits;
  assign take = job_valid_i && job_ready_o;

  always_comb begin
    case (verdict_e'(job_i.verdict))
      VERD_LEFT:   req = MSK_LEFT;
      VERD_CENTER: req = MSK_CENTER;
      VERD_RIGHT:  req = MSK_RIGHT;
      default:     req = MSK_NONE;
    endcase
    drv_d = MSK_NONE;
    if (op == OP_TICK) begin
      if (cool_q != 8'd0) drv_d = MSK_NONE;
      else if (armed_q) drv_d = smask_q;
      else if (pend_q == MSK_LEFT || pend_q == MSK_CENTER || pend_q == MSK_RIGHT)
        drv_d = pend_q;
    end
    res = '0;
    if (op == OP_VERDICT) begin
      res.verdict = job_i.verdict;
      res.request_published = (req != MSK_NONE) && (rearm_q == 2'd0);
      if (req != MSK_NONE) begin
        res.target_x = job_i.target_x;
        res.target_y = job_i.target_y;
        res.aim_offset = {1'b0, job_i.target_x} - {1'b0, cfg_i.ccol};
        res.peak_col = job_i.peak_col;
        res.valley_col = job_i.valley_col;
      end
    end else begin
      res.result_kind = 1'b1;
      res.laser_left_on = drv_d == MSK_LEFT;
      res.laser_center_on = drv_d == MSK_CENTER;
      res.laser_right_on = drv_d == MSK_RIGHT;
      res.buzzer_on = drv_d != MSK_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emits) od_q <= res;
  end
  assign out_data_o  = od_q;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      rearm_q <= '0;
      pend_q <= MSK_NONE;
      armed_q <= 1'b0;
      smask_q <= MSK_NONE;
      cool_q <= '0;
      drive_q <= MSK_NONE;
    end else begin
      if (take && emits) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (take) begin
        unique case (op)
          OP_DETRST: begin
            rearm_q <= '0;
            pend_q <= MSK_NONE;
          end
          OP_INHIB: begin
            pend_q <= MSK_NONE;
            armed_q <= 1'b0;
            smask_q <= MSK_NONE;
            cool_q <= '0;
            drive_q <= MSK_NONE;
          end
          OP_TICK: begin
            drive_q <= drv_d;
            pend_q <= MSK_NONE;
            if (cool_q != 8'd0) begin
              cool_q <= cool_q - 8'd1;
              armed_q <= 1'b0;
              smask_q <= MSK_NONE;
            end else if (armed_q) begin
              armed_q <= 1'b0;
              smask_q <= MSK_NONE;
              cool_q <= cfg_i.cool;
            end else begin
              armed_q <= drv_d != MSK_NONE;
              smask_q <= drv_d;
            end
          end
          default: begin
            if (job_i.frame_bad) begin
              pend_q <= MSK_NONE;
              if (rearm_q != 2'd0) rearm_q <= 2'd1;
            end else if (req == MSK_NONE) begin
              pend_q <= MSK_NONE;
              if (rearm_q == 2'd1) rearm_q <= 2'd2;
              else if (rearm_q >= 2'd2) rearm_q <= 2'd0;
            end else begin
              if (rearm_q == 2'd0) pend_q <= req;
              rearm_q <= 2'd1;
            end
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q && $stable(od_q)) else $error("result lost");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(drive_q)) else $error("drive not one-hot");
  a_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> $onehot(smask_q)) else $error("armed without mask");
`endif
endmodule

FILE: hw/rtl/lane_notch_detector_with_shot_timer_top.sv
// Top level of the lane notch detector with shot timer.
//  channel | dir | beat
//  in_if   | in  | kind, edges, lost-row limits, last_row
//  out_if  | out | verdict or laser drive result
//  cfg_if  | in  | register index and 8-bit value
// One item per clock while the queue has room: the front classifies in the
// accepting cycle, a two-entry queue feeds the back, and a result register
// holds the beat until taken. An item's result passes the queue, then that register.
// Reset clears all control state at once; no clearing pass.
// Output stalls back up through the queue into in_if.ready.
module lane_notch_detector_with_shot_timer_top import lnd_pkg::*; #(
  parameter int IMAGE_WIDTH    = 188,
  parameter int FIRST_ROW      = 61,
  parameter int ROW_STEP       = 2,
  parameter int ROWS_PER_FRAME = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  lnd_in_if.sink    in_if,
  lnd_out_if.source out_if,
  lnd_cfg_if.sink   cfg_if
);
  cfg_t cfg_q;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  // Configuration registers, always writable.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth <= 8'd8;
      cfg_q.tol   <= 8'd4;
      cfg_q.width <= 8'd20;
      cfg_q.ccol  <= 8'd94;
      cfg_q.cool  <= 8'd34;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_DEPTH: cfg_q.depth <= cfg_if.wdata;
        REG_TOL:   cfg_q.tol   <= cfg_if.wdata;
        REG_WIDTH: cfg_q.width <= cfg_if.wdata;
        REG_CCOL:  cfg_q.ccol  <= cfg_if.wdata;
        REG_COOL:  cfg_q.cool  <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  lnd_front #(
    .IMAGE_WIDTH(IMAGE_WIDTH), .FIRST_ROW(FIRST_ROW),
    .ROW_STEP(ROW_STEP), .ROWS_PER_FRAME(ROWS_PER_FRAME)
  ) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(in_if.valid), .in_data_i(in_if.data), .in_ready_o(in_if.ready),
    .job_valid_o(fq_valid), .job_o(fq_job), .job_ready_i(fq_ready)
  );

  lnd_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_data_i(fq_job), .wr_ready_o(fq_ready),
    .rd_valid_o(qb_valid), .rd_data_o(qb_job), .rd_ready_i(qb_ready)
  );

  lnd_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .job_valid_i(qb_valid), .job_i(qb_job), .job_ready_o(qb_ready),
    .out_valid_o(out_if.valid), .out_data_o(out_if.data), .out_ready_i(out_if.ready)
  );
endmodule
